/* rtl/byte_ring_deque_macros.svh */
// Assertion macros shared by the byte ring deque RTL.
// No dependencies; included by modules that carry assertions.
`ifndef BYTE_RING_DEQUE_MACROS_SVH
`define BYTE_RING_DEQUE_MACROS_SVH

// same-cycle implication
`define BRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BRD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/brd_pkg.sv */
// Package for the byte ring deque: widths, opcodes, status codes, FSM state
// and controller/datapath interface structs. No dependencies.
package brd_pkg;

    localparam int STORE_DEPTH = 4096;
    localparam int MAX_BURST   = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int N_W         = 7;
    localparam int IDX_W       = 12;
    localparam int DATA_W      = 8;
    localparam int OP_W        = 4;
    localparam int ST_W        = 3;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK   = 4'd0,
        OP_PUSH_FRONT  = 4'd1,
        OP_POP_BACK    = 4'd2,
        OP_POP_FRONT   = 4'd3,
        OP_POP_FRONT_N = 4'd4,
        OP_READ_FRONT  = 4'd5,
        OP_READ_BACK   = 4'd6,
        OP_READ_AT     = 4'd7,
        OP_READ_FRONT_N= 4'd8,
        OP_BURST_PUSH  = 4'd9
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_EMPTY = 3'd2,
        ST_LARGE = 3'd3,
        ST_INDEX = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic rd_beat;
    } t_cmd;

    typedef struct packed {
        logic need_read;
        logic last_beat;
    } t_sts;

endpackage

/* rtl/brd_ctrl.sv */
// Controller FSM for the byte ring deque: sequences load, execute and read beats.
// Depends on brd_pkg and byte_ring_deque_macros.svh.
`include "byte_ring_deque_macros.svh"

module brd_ctrl
    import brd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = i_sts.need_read ? S_READ : S_IDLE;
            end
            S_READ: begin
                if (i_sts.last_beat) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_busy = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                o_cmd.load = i_start;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_READ: begin
                o_cmd.rd_beat = 1'b1;
            end
            default: o_busy = 1'b1;
        endcase
    end

    `BRD_ASSERT_NXT(a_accept_exec, i_clk, i_rst_n, r_state == S_IDLE && i_start,
        r_state == S_EXEC, "accepted beat did not enter execute")
    `BRD_ASSERT_NXT(a_exec_leaves, i_clk, i_rst_n, r_state == S_EXEC,
        r_state == S_IDLE || r_state == S_READ, "execute lasted more than one cycle")
    `BRD_ASSERT_NXT(a_read_ends, i_clk, i_rst_n, r_state == S_READ && i_sts.last_beat,
        r_state == S_IDLE, "read run did not end on last beat")

endmodule

/* rtl/brd_dp.sv */
// Datapath for the byte ring deque: capacity register, ring pointers, burst
// state, byte store and result registers. Depends on brd_pkg and the macros.
`include "byte_ring_deque_macros.svh"

module brd_dp
    import brd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_wdata,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [DATA_W-1:0] i_data_in,
    input  logic [N_W-1:0]    i_count,
    input  logic [IDX_W-1:0]  i_index,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data_out,
    output logic [ST_W-1:0]   o_status,
    output logic [CNT_W-1:0]  o_fill_count,
    output logic              o_is_full,
    output logic              o_is_empty,
    output logic              o_last
);

    function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] i,
                                                   input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] s;
        s = {1'b0, i} + CNT_W'(1);
        return (s >= c) ? '0 : s[ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] wrap_dec(input logic [ADDR_W-1:0] i,
                                                   input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] m;
        m = c - CNT_W'(1);
        return (i == '0) ? m[ADDR_W-1:0] : i - ADDR_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] i,
                                                   input logic [CNT_W-1:0] step,
                                                   input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] s;
        logic [CNT_W-1:0] d;
        s = {1'b0, i} + step;
        d = s - c;
        return (s >= c) ? d[ADDR_W-1:0] : s[ADDR_W-1:0];
    endfunction

    // registers
    logic [CNT_W-1:0]  r_cap;
    logic [ADDR_W-1:0] r_head, r_tail;
    logic [CNT_W-1:0]  r_held;
    logic [N_W-1:0]    r_brem;
    logic              r_brej;
    t_op               r_op;
    logic [DATA_W-1:0] r_din;
    logic [N_W-1:0]    r_n;
    logic [IDX_W-1:0]  r_idx;
    logic [ADDR_W-1:0] r_rd_addr;
    logic [DATA_W-1:0] r_rd_data;
    logic [N_W-1:0]    r_left;
    logic [DATA_W-1:0] r_mem [STORE_DEPTH];

    // next values
    logic [ADDR_W-1:0] n_head, n_tail;
    logic [CNT_W-1:0]  n_held;
    logic [N_W-1:0]    n_brem;
    logic              n_brej;

    logic [CNT_W-1:0]  cap;
    logic [CNT_W-1:0]  n_ext, idx_ext, free_cnt;
    logic              full, empty, too_large;
    t_status           st;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              need_read;
    logic [ADDR_W-1:0] raddr_exec, rd_addr;
    logic [N_W-1:0]    rem0, rem1;
    logic              rej0;

    always_comb begin
        if (r_cap == '0) begin
            cap = CNT_W'(1);
        end else if (r_cap > CNT_W'(STORE_DEPTH)) begin
            cap = CNT_W'(STORE_DEPTH);
        end else begin
            cap = r_cap;
        end
    end

    assign n_ext     = {{(CNT_W-N_W){1'b0}}, r_n};
    assign idx_ext   = CNT_W'(r_idx);
    assign free_cnt  = cap - r_held;
    assign full      = (r_held == cap);
    assign empty     = (r_held == '0);
    assign too_large = (n_ext > r_held) || (r_n > N_W'(MAX_BURST));

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_held     = r_held;
        n_brem     = r_brem;
        n_brej     = r_brej;
        st         = ST_OK;
        we         = 1'b0;
        waddr      = r_tail;
        need_read  = 1'b0;
        raddr_exec = r_head;
        rem0       = (r_brem == '0) ? r_n : r_brem;
        rej0       = (r_brem == '0) ? ((r_n > N_W'(MAX_BURST)) || (n_ext > free_cnt))
                                    : r_brej;
        rem1       = rem0 - N_W'(1);
        if (r_op != OP_BURST_PUSH) begin
            n_brem = '0;
            n_brej = 1'b0;
        end
        unique case (r_op)
            OP_PUSH_BACK: begin
                if (full) begin
                    st = ST_FULL;
                end else begin
                    we     = 1'b1;
                    n_tail = wrap_inc(r_tail, cap);
                    n_held = r_held + CNT_W'(1);
                end
            end
            OP_PUSH_FRONT: begin
                if (full) begin
                    st = ST_FULL;
                end else begin
                    we     = 1'b1;
                    n_head = wrap_dec(r_head, cap);
                    waddr  = n_head;
                    n_held = r_held + CNT_W'(1);
                end
            end
            OP_POP_BACK: begin
                if (empty) begin
                    st = ST_EMPTY;
                end else begin
                    n_tail = wrap_dec(r_tail, cap);
                    n_held = r_held - CNT_W'(1);
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    st = ST_EMPTY;
                end else begin
                    n_head = wrap_inc(r_head, cap);
                    n_held = r_held - CNT_W'(1);
                end
            end
            OP_POP_FRONT_N: begin
                if (empty) begin
                    st = ST_EMPTY;
                end else if (too_large) begin
                    st = ST_LARGE;
                end else begin
                    n_head = wrap_add(r_head, n_ext, cap);
                    n_held = r_held - n_ext;
                end
            end
            OP_READ_FRONT: begin
                if (empty) st = ST_EMPTY;
                else need_read = 1'b1;
            end
            OP_READ_BACK: begin
                raddr_exec = wrap_dec(r_tail, cap);
                if (empty) st = ST_EMPTY;
                else need_read = 1'b1;
            end
            OP_READ_AT: begin
                raddr_exec = wrap_add(r_head, idx_ext, cap);
                if (empty) st = ST_EMPTY;
                else if (idx_ext >= r_held) st = ST_INDEX;
                else need_read = 1'b1;
            end
            OP_READ_FRONT_N: begin
                if (empty) st = ST_EMPTY;
                else if (too_large) st = ST_LARGE;
                else if (r_n != '0) need_read = 1'b1;
            end
            OP_BURST_PUSH: begin
                priority if (r_brem == '0 && r_n == '0) begin
                    st = ST_LARGE;
                end else if (rej0) begin
                    st     = ST_LARGE;
                    n_brem = rem1;
                    n_brej = (rem1 != '0);
                end else if (full) begin
                    st     = ST_FULL;
                    n_brem = '0;
                    n_brej = 1'b0;
                end else begin
                    we     = 1'b1;
                    n_tail = wrap_inc(r_tail, cap);
                    n_held = r_held + CNT_W'(1);
                    n_brem = rem1;
                    n_brej = 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign rd_addr = i_cmd.exec ? raddr_exec : wrap_inc(r_rd_addr, cap);

    assign o_sts.need_read = need_read;
    assign o_sts.last_beat = (r_left == N_W'(1));

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_op'(i_opcode);
            r_din <= i_data_in;
            r_n   <= i_count;
            r_idx <= i_index;
        end
    end

    // ring state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= CNT_W'(STORE_DEPTH);
            r_head <= '0;
            r_tail <= '0;
            r_held <= '0;
            r_brem <= '0;
            r_brej <= 1'b0;
        end else if (i_cfg_we) begin
            r_cap  <= i_cfg_wdata;
            r_head <= '0;
            r_tail <= '0;
            r_held <= '0;
            r_brem <= '0;
            r_brej <= 1'b0;
        end else if (i_cmd.exec) begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_held <= n_held;
            r_brem <= n_brem;
            r_brej <= n_brej;
        end
    end

    // byte store
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && we) begin
            r_mem[waddr] <= r_din;
        end
        if (i_cmd.exec || i_cmd.rd_beat) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_addr <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_left <= (r_op == OP_READ_FRONT_N) ? r_n : N_W'(1);
        end else if (i_cmd.rd_beat) begin
            r_left <= r_left - N_W'(1);
        end
    end

    // result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= (i_cmd.exec && !need_read) || i_cmd.rd_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && !need_read) begin
            o_data_out   <= '0;
            o_status     <= st;
            o_fill_count <= n_held;
            o_is_full    <= (n_held == cap);
            o_is_empty   <= (n_held == '0);
            o_last       <= 1'b1;
        end else if (i_cmd.rd_beat) begin
            o_data_out   <= r_rd_data;
            o_status     <= ST_OK;
            o_fill_count <= r_held;
            o_is_full    <= full;
            o_is_empty   <= empty;
            o_last       <= (r_left == N_W'(1));
        end
    end

    `BRD_ASSERT_NOW(a_held_le_cap, i_clk, i_rst_n, 1'b1, r_held <= cap,
        "fill count above capacity")
    `BRD_ASSERT_NOW(a_ring_geom, i_clk, i_rst_n, 1'b1,
        wrap_add(r_head, r_held, cap) == r_tail, "head, tail and fill count disagree")
    `BRD_ASSERT_NOW(a_rej_open, i_clk, i_rst_n, r_brej, r_brem != '0,
        "rejected burst with nothing remaining")

endmodule

/* rtl/byte_ring_deque.sv */
// Byte ring deque top level: one item per start; a non-read item gives its
// result from registers loaded in the execute state, and the block is idle
// again once execute ends. A read fetches its first byte from the store in
// execute and registers it to the output on the first read beat; an n-byte
// read then streams one byte per cycle, paced by the single read port of the
// byte store. Synchronous active-low reset empties the ring and sets capacity to 4096; store contents are not cleared.
module byte_ring_deque
    import brd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_wdata,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [DATA_W-1:0] i_data_in,
    input  logic [N_W-1:0]    i_count,
    input  logic [IDX_W-1:0]  i_index,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data_out,
    output logic [ST_W-1:0]   o_status,
    output logic [CNT_W-1:0]  o_fill_count,
    output logic              o_is_full,
    output logic              o_is_empty,
    output logic              o_last
);

    t_cmd cmd;
    t_sts sts;

    brd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    brd_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_opcode     (i_opcode),
        .i_data_in    (i_data_in),
        .i_count      (i_count),
        .i_index      (i_index),
        .o_valid      (o_valid),
        .o_data_out   (o_data_out),
        .o_status     (o_status),
        .o_fill_count (o_fill_count),
        .o_is_full    (o_is_full),
        .o_is_empty   (o_is_empty),
        .o_last       (o_last)
    );

endmodule

/* sim/brd_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for byte_ring_deque: keeps a shadow ring, predicts every result beat
// on accept and compares it with the beats the block emits. Depends on brd_pkg.
module brd_checker
    import brd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_wdata,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [DATA_W-1:0] i_data_in,
    input  logic [N_W-1:0]    i_count,
    input  logic [IDX_W-1:0]  i_index,
    input  logic              i_valid,
    input  logic [DATA_W-1:0] i_data_out,
    input  logic [ST_W-1:0]   i_status,
    input  logic [CNT_W-1:0]  i_fill_count,
    input  logic              i_is_full,
    input  logic              i_is_empty,
    input  logic              i_last,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [ST_W-1:0]   status;
        logic [CNT_W-1:0]  fill;
        logic              full;
        logic              empty;
        logic              last;
    } t_ring_beat;

    logic [DATA_W-1:0] shadow_mem [STORE_DEPTH];
    logic [CNT_W-1:0]  cap_reg = CNT_W'(STORE_DEPTH);
    logic [ADDR_W-1:0] head_ptr = '0;
    logic [ADDR_W-1:0] tail_ptr = '0;
    logic [CNT_W-1:0]  held = '0;
    logic [N_W-1:0]    burst_left = '0;
    logic              burst_drop = 1'b0;
    t_ring_beat        beats_due [$];
    int                fails = 0;

    function automatic logic [CNT_W-1:0] cap_in_use();
        if (cap_reg == 0) return CNT_W'(1);
        if (cap_reg > STORE_DEPTH) return CNT_W'(STORE_DEPTH);
        return cap_reg;
    endfunction

    function automatic logic [ADDR_W-1:0] ring_fwd(logic [ADDR_W-1:0] pos, int step);
        int sum;
        sum = int'(pos) + step;
        if (sum >= int'(cap_in_use())) sum -= int'(cap_in_use());
        return ADDR_W'(sum);
    endfunction

    function automatic logic [ADDR_W-1:0] ring_back(logic [ADDR_W-1:0] pos);
        return (pos == 0) ? ADDR_W'(cap_in_use() - 1) : pos - 1'b1;
    endfunction

    function automatic void drop_contents();
        head_ptr   = '0;
        tail_ptr   = '0;
        held       = '0;
        burst_left = '0;
        burst_drop = 1'b0;
    endfunction

    task automatic emit(logic [DATA_W-1:0] data, t_status st, logic last);
        t_ring_beat b;
        b.data   = data;
        b.status = st;
        b.fill   = held;
        b.full   = (held == cap_in_use());
        b.empty  = (held == 0);
        b.last   = last;
        beats_due.push_back(b);
    endtask

    task automatic predict_item(logic [OP_W-1:0] op, logic [DATA_W-1:0] d,
                                logic [N_W-1:0] n, logic [IDX_W-1:0] idx);
        logic [CNT_W-1:0]  cap;
        logic [DATA_W-1:0] rd;
        t_status           st;
        logic              streamed;
        cap      = cap_in_use();
        rd       = '0;
        st       = ST_OK;
        streamed = 1'b0;
        if (op != OP_BURST_PUSH) begin
            burst_left = '0;
            burst_drop = 1'b0;
        end
        case (op)
            OP_PUSH_BACK: begin
                if (held == cap) begin
                    st = ST_FULL;
                end else begin
                    shadow_mem[tail_ptr] = d;
                    tail_ptr = ring_fwd(tail_ptr, 1);
                    held++;
                end
            end
            OP_PUSH_FRONT: begin
                if (held == cap) begin
                    st = ST_FULL;
                end else begin
                    head_ptr = ring_back(head_ptr);
                    shadow_mem[head_ptr] = d;
                    held++;
                end
            end
            OP_POP_BACK: begin
                if (held == 0) begin
                    st = ST_EMPTY;
                end else begin
                    tail_ptr = ring_back(tail_ptr);
                    held--;
                end
            end
            OP_POP_FRONT: begin
                if (held == 0) begin
                    st = ST_EMPTY;
                end else begin
                    head_ptr = ring_fwd(head_ptr, 1);
                    held--;
                end
            end
            OP_POP_FRONT_N: begin
                if (held == 0) begin
                    st = ST_EMPTY;
                end else if (n > held || n > MAX_BURST) begin
                    st = ST_LARGE;
                end else begin
                    head_ptr = ring_fwd(head_ptr, n);
                    held -= n;
                end
            end
            OP_READ_FRONT: begin
                if (held == 0) st = ST_EMPTY;
                else rd = shadow_mem[head_ptr];
            end
            OP_READ_BACK: begin
                if (held == 0) st = ST_EMPTY;
                else rd = shadow_mem[ring_back(tail_ptr)];
            end
            OP_READ_AT: begin
                if (held == 0) st = ST_EMPTY;
                else if (idx >= held) st = ST_INDEX;
                else rd = shadow_mem[ring_fwd(head_ptr, idx)];
            end
            OP_READ_FRONT_N: begin
                if (held == 0) begin
                    st = ST_EMPTY;
                end else if (n > held || n > MAX_BURST) begin
                    st = ST_LARGE;
                end else if (n != 0) begin
                    streamed = 1'b1;
                    for (int k = 0; k < n; k++)
                        emit(shadow_mem[ring_fwd(head_ptr, k)], ST_OK, k == n - 1);
                end
            end
            OP_BURST_PUSH: begin
                if (burst_left == 0 && n == 0) begin
                    st = ST_LARGE;
                end else begin
                    if (burst_left == 0) begin
                        burst_left = n;
                        burst_drop = (n > MAX_BURST) || (n > cap - held);
                    end
                    burst_left--;
                    if (burst_drop) begin
                        st = ST_LARGE;
                        if (burst_left == 0) burst_drop = 1'b0;
                    end else if (held == cap) begin
                        st = ST_FULL;
                        burst_left = '0;
                    end else begin
                        shadow_mem[tail_ptr] = d;
                        tail_ptr = ring_fwd(tail_ptr, 1);
                        held++;
                    end
                end
            end
            default: ;
        endcase
        if (!streamed) emit(rd, st, 1'b1);
    endtask

    task automatic check_field(string name, logic [CNT_W-1:0] want_v,
                               logic [CNT_W-1:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_ring_beat want;
        if (!i_rst_n) begin
            cap_reg = CNT_W'(STORE_DEPTH);
            drop_contents();
            beats_due.delete();
        end else begin
            if (i_valid) begin
                if (beats_due.size() == 0) begin
                    $error("result beat with nothing expected");
                    fails++;
                end else begin
                    want = beats_due.pop_front();
                    check_field("data_out", want.data, i_data_out);
                    check_field("status", want.status, i_status);
                    check_field("fill_count", want.fill, i_fill_count);
                    check_field("is_full", want.full, i_is_full);
                    check_field("is_empty", want.empty, i_is_empty);
                    check_field("last", want.last, i_last);
                end
            end
            if (i_cfg_we) begin
                cap_reg = i_cfg_wdata;
                drop_contents();
            end
            if (i_start && !i_busy) predict_item(i_opcode, i_data_in, i_count, i_index);
        end
        o_fail_count <= fails;
        o_pending    <= beats_due.size();
    end

endmodule

/* sim/tb_byte_ring_deque.sv */
`timescale 1ns / 1ps
// Testbench top for byte_ring_deque: clock, reset, directed and random stimulus,
// capacity changes and the verdict. Depends on brd_pkg, the block and brd_checker.
module tb_byte_ring_deque;
    import brd_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_LO = OP_BURST_PUSH + 1;
    localparam logic [OP_W-1:0] OP_SPARE_HI = '1;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              i_cfg_we = 1'b0;
    logic [CNT_W-1:0]  i_cfg_wdata = '0;
    logic [OP_W-1:0]   i_opcode = '0;
    logic [DATA_W-1:0] i_data_in = '0;
    logic [N_W-1:0]    i_count = '0;
    logic [IDX_W-1:0]  i_index = '0;
    logic              o_valid;
    logic [DATA_W-1:0] o_data_out;
    logic [ST_W-1:0]   o_status;
    logic [CNT_W-1:0]  o_fill_count;
    logic              o_is_full;
    logic              o_is_empty;
    logic              o_last;
    int                fail_count;
    int                pending;
    int                gap_max = 19;
    int                items_issued = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    byte_ring_deque dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_opcode     (i_opcode),
        .i_data_in    (i_data_in),
        .i_count      (i_count),
        .i_index      (i_index),
        .o_valid      (o_valid),
        .o_data_out   (o_data_out),
        .o_status     (o_status),
        .o_fill_count (o_fill_count),
        .o_is_full    (o_is_full),
        .o_is_empty   (o_is_empty),
        .o_last       (o_last)
    );

    brd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_opcode     (i_opcode),
        .i_data_in    (i_data_in),
        .i_count      (i_count),
        .i_index      (i_index),
        .i_valid      (o_valid),
        .i_data_out   (o_data_out),
        .i_status     (o_status),
        .i_fill_count (o_fill_count),
        .i_is_full    (o_is_full),
        .i_is_empty   (o_is_empty),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    task automatic issue(logic [OP_W-1:0] op, logic [DATA_W-1:0] d,
                         logic [N_W-1:0] n, logic [IDX_W-1:0] idx);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_opcode  <= op;
        i_data_in <= d;
        i_count   <= n;
        i_index   <= idx;
        do @(posedge i_clk); while (busy);
        items_issued++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || busy);
    endtask

    task automatic set_capacity(logic [CNT_W-1:0] cap);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [N_W-1:0] rand_count();
        int r;
        r = $urandom_range(0, 31);
        if (r == 0) return '0;
        if (r == 1) return N_W'($urandom_range(MAX_BURST + 1, 127));
        if (r < 6) return N_W'($urandom_range(1, MAX_BURST));
        return N_W'($urandom_range(1, 8));
    endfunction

    function automatic logic [IDX_W-1:0] rand_index();
        if ($urandom_range(0, 3) == 0) return IDX_W'($urandom_range(0, STORE_DEPTH - 1));
        return IDX_W'($urandom_range(0, 10));
    endfunction

    // Stretches lean toward filling, draining or neither so full and empty
    // both get visited; bursts are mostly complete, some cut short.
    task automatic run_random(int n_items);
        int target, run_len, bias, pick, push_w, burst_w, pop_w, len;
        logic [N_W-1:0] n;
        target  = items_issued + n_items;
        run_len = 0;
        bias    = 2;
        while (items_issued < target) begin
            if (run_len == 0) begin
                run_len = $urandom_range(8, 30);
                bias    = $urandom_range(0, 2);
                gap_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
            end
            run_len--;
            case (bias)
                0: begin
                    push_w = 50; burst_w = 20; pop_w = 10;
                end
                1: begin
                    push_w = 10; burst_w = 5; pop_w = 50;
                end
                default: begin
                    push_w = 25; burst_w = 12; pop_w = 25;
                end
            endcase
            pick = $urandom_range(0, 99);
            if (pick < push_w) begin
                issue(pick[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom_range(0, 255),
                      rand_count(), rand_index());
            end else if (pick < push_w + burst_w) begin
                n = rand_count();
                if (n == 0) len = 1;
                else if (n > MAX_BURST) len = $urandom_range(1, 6);
                else if ($urandom_range(0, 4) == 0) len = $urandom_range(1, n);
                else len = n;
                for (int k = 0; k < len; k++)
                    issue(OP_BURST_PUSH, $urandom_range(0, 255),
                          (k == 0) ? n : rand_count(), rand_index());
            end else if (pick < push_w + burst_w + pop_w) begin
                case ($urandom_range(0, 2))
                    0: issue(OP_POP_BACK, $urandom_range(0, 255), rand_count(), rand_index());
                    1: issue(OP_POP_FRONT, $urandom_range(0, 255), rand_count(), rand_index());
                    default: issue(OP_POP_FRONT_N, $urandom_range(0, 255), rand_count(),
                                   rand_index());
                endcase
            end else if (pick < 97) begin
                case ($urandom_range(0, 3))
                    0: issue(OP_READ_FRONT, $urandom_range(0, 255), rand_count(), rand_index());
                    1: issue(OP_READ_BACK, $urandom_range(0, 255), rand_count(), rand_index());
                    2: issue(OP_READ_AT, $urandom_range(0, 255), rand_count(), rand_index());
                    default: issue(OP_READ_FRONT_N, $urandom_range(0, 255), rand_count(),
                                   rand_index());
                endcase
            end else begin
                issue($urandom_range(OP_SPARE_LO, OP_SPARE_HI), $urandom_range(0, 255),
                      rand_count(), rand_index());
            end
        end
    endtask

    initial begin
        logic [CNT_W-1:0] phase_caps [9];
        phase_caps = '{CNT_W'(STORE_DEPTH), 13'd1, 13'd2, 13'd5, 13'd64, 13'd65,
                       13'd300, 13'd0, 13'd3};
        phase_caps[7] = CNT_W'($urandom_range(6, STORE_DEPTH - 1));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // small ring so that full, wrap and exact-fill bursts come quickly
        set_capacity(13'd4);
        issue(OP_POP_FRONT, 8'h00, 7'd0, '0);
        issue(OP_POP_BACK, 8'h00, 7'd0, '0);
        issue(OP_POP_FRONT_N, 8'h00, 7'd1, '0);
        issue(OP_READ_FRONT, 8'h00, 7'd0, '0);
        issue(OP_READ_BACK, 8'h00, 7'd0, '0);
        issue(OP_READ_AT, 8'h00, 7'd0, '0);
        issue(OP_READ_FRONT_N, 8'h00, 7'd1, '0);
        issue(OP_SPARE_HI, 8'h00, 7'd0, '0);
        issue(OP_BURST_PUSH, 8'h11, 7'd0, '0);
        issue(OP_PUSH_FRONT, 8'hFF, 7'd0, '0);
        issue(OP_PUSH_BACK, 8'h00, 7'd0, '0);
        issue(OP_READ_AT, 8'h00, 7'd0, IDX_W'(1));
        issue(OP_READ_AT, 8'h00, 7'd0, IDX_W'(STORE_DEPTH - 1));
        issue(OP_READ_FRONT_N, 8'h00, 7'd0, '0);
        issue(OP_READ_FRONT_N, 8'h00, 7'd127, '0);
        issue(OP_BURST_PUSH, 8'hA5, 7'd2, '0);
        issue(OP_BURST_PUSH, 8'h5A, 7'd0, '0);
        issue(OP_PUSH_BACK, 8'h77, 7'd0, '0);
        issue(OP_PUSH_FRONT, 8'h88, 7'd0, '0);
        issue(OP_READ_FRONT_N, 8'h00, 7'd4, '0);
        issue(OP_BURST_PUSH, 8'h33, 7'd1, '0);
        issue(OP_POP_FRONT_N, 8'h00, 7'd64, '0);
        issue(OP_POP_FRONT_N, 8'h00, 7'd2, '0);
        issue(OP_POP_BACK, 8'h00, 7'd0, '0);
        issue(OP_BURST_PUSH, 8'hC3, 7'd3, '0);
        issue(OP_READ_BACK, 8'h00, 7'd0, '0);
        issue(OP_POP_FRONT, 8'h00, 7'd0, '0);

        foreach (phase_caps[p]) begin
            set_capacity(phase_caps[p]);
            run_random(45);
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("byte_ring_deque verification clean");
        else
            $display("byte_ring_deque verification failed");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("byte_ring_deque verification failed");
        $finish;
    end

endmodule
